>>> hw/rtl/pbrle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pbrle_pkg;

	localparam int BYTE_W     = 8;
	localparam int BEAT_BYTES = 8;
	localparam int BEAT_W     = BYTE_W * BEAT_BYTES;
	localparam int COUNT_W    = 4;
	// shortest stretch that is sent as a run packet
	localparam int RUN_MIN    = 3;

	typedef logic [BYTE_W-1:0]  byte_t;
	typedef logic [BEAT_W-1:0]  beat_t;
	typedef logic [COUNT_W-1:0] count_t;

endpackage

`default_nettype wire

>>> hw/rtl/pbrle_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pbrle_in_if import pbrle_pkg::*; ();

	logic  valid;
	logic  ready;
	byte_t in_byte;
	logic  row_end;

	modport source (output valid, output in_byte, output row_end, input ready);
	modport sink (input valid, input in_byte, input row_end, output ready);

endinterface

`default_nettype wire

>>> hw/rtl/pbrle_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pbrle_out_if import pbrle_pkg::*; ();

	logic   valid;
	logic   ready;
	beat_t  out_bytes;
	count_t out_count;
	logic   row_done;

	modport source (output valid, output out_bytes, output out_count, output row_done,
		input ready);
	modport sink (input valid, input out_bytes, input out_count, input row_done,
		output ready);

endinterface

`default_nettype wire

>>> hw/rtl/packbits_run_length_encoder.sv
// steps: a byte that closes nothing is accepted, then decided; a short stretch adds an add
//   step per joined byte plus a re-decide; a packet sends its header, then its run byte or data
// flow: a byte is taken only in idle, once the last is through; a step with output ends in a
//   done step for its last word; byte pushes stall while a full word waits on the receiver
// reset: arst_n clears counts, sequencer, byte packer and output word; the literal store
//   is not cleared and is only read below the literal count
`timescale 1ns / 1ps
`default_nettype none

module packbits_run_length_encoder import pbrle_pkg::*; #(
	parameter int MAX_PACKET = 128
) (
	input  wire          clk,
	input  wire          arst_n,
	pbrle_in_if.sink     raw,
	pbrle_out_if.source  enc
);

	localparam int CW = $clog2(MAX_PACKET + 1);   // counts up to MAX_PACKET
	localparam int AW = $clog2(MAX_PACKET);       // literal store address

	// sequencer states
	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_DECIDE  = 3'd1;
	localparam logic [2:0] S_ADD     = 3'd2;
	localparam logic [2:0] S_LIT_HDR = 3'd3;
	localparam logic [2:0] S_LIT_DAT = 3'd4;
	localparam logic [2:0] S_RUN_HDR = 3'd5;
	localparam logic [2:0] S_RUN_BYT = 3'd6;
	localparam logic [2:0] S_DONE    = 3'd7;

	// literal store: one write port (add), one registered read port (flush)
	byte_t mem [MAX_PACKET];

	logic [2:0]    state_q;
	logic [CW-1:0] lc_q;        // literal count
	logic [CW-1:0] rc_q;        // pending stretch length
	byte_t         rb_q;        // pending stretch byte
	byte_t         x_q;         // current input byte
	logic          end_q;       // current input closes the row
	logic          ext_q;       // current byte already merged into the stretch
	logic [CW-1:0] idx_q;       // flush read pointer
	byte_t         rdata_s1;    // literal byte read from the store
	logic          rvalid_s1;

	// byte packer and output word
	beat_t         acc_q;
	count_t        acc_n_q;
	logic          out_valid_q;
	beat_t         out_bytes_q;
	count_t        out_count_q;
	logic          out_done_q;

	logic          out_free;
	logic          push_req;
	byte_t         push_byte;
	logic          push_ok;
	logic          do_push;
	logic          acc_full;
	logic          rd_issue;
	logic          lit_last;

	// decide-step values
	logic          c0;
	logic [CW-1:0] rc_n;
	logic [CW-1:0] close_rc;
	logic [2:0]    close_state;
	logic [2:0]    decide_next;

	assign raw.ready     = (state_q == S_IDLE);
	assign enc.valid     = out_valid_q;
	assign enc.out_bytes = out_bytes_q;
	assign enc.out_count = out_count_q;
	assign enc.row_done  = out_done_q;

	assign out_free = !out_valid_q || enc.ready;
	assign acc_full = (acc_n_q == count_t'(BEAT_BYTES));
	assign push_ok  = !acc_full || out_free;
	assign do_push  = push_req && push_ok;

	// flush reads run one ahead of the push; hold while the pushed byte stalls
	assign rd_issue = (state_q == S_LIT_DAT) && (idx_q != lc_q) && (!rvalid_s1 || push_ok);
	assign lit_last = (idx_q == lc_q) && (!rvalid_s1 || push_ok);

	// byte source for the packer
	always_comb begin
		push_req  = 1'b0;
		push_byte = '0;
		case (state_q)
			S_LIT_HDR: begin
				push_req  = 1'b1;
				push_byte = byte_t'(lc_q - CW'(1));
			end
			S_LIT_DAT: begin
				push_req  = rvalid_s1;
				push_byte = rdata_s1;
			end
			S_RUN_HDR: begin
				// header is 1 - length, modulo 256
				push_req  = 1'b1;
				push_byte = byte_t'(1) - byte_t'(rc_q);
			end
			S_RUN_BYT: begin
				push_req  = 1'b1;
				push_byte = rb_q;
			end
			default: begin
				push_req  = 1'b0;
				push_byte = '0;
			end
		endcase
	end

	// decide: stretch break on a new byte, then merge, long stretch, row end
	always_comb begin
		c0 = !ext_q && (rc_q != '0) && (x_q != rb_q);
		if (ext_q) begin
			rc_n = rc_q;
		end else if (rc_q == '0) begin
			rc_n = CW'(1);
		end else begin
			rc_n = rc_q + CW'(1);
		end
		close_rc = c0 ? rc_q : rc_n;
		// a run first flushes the literals; a short stretch joins them
		if (close_rc >= CW'(RUN_MIN)) begin
			close_state = (lc_q != '0) ? S_LIT_HDR : S_RUN_HDR;
		end else begin
			close_state = S_ADD;
		end
		decide_next = S_IDLE;
		if (c0) begin
			decide_next = close_state;
		end else if (rc_n >= CW'(MAX_PACKET)) begin
			decide_next = close_state;
		end else if (end_q && (rc_n != '0)) begin
			decide_next = close_state;
		end else if (end_q && (lc_q != '0)) begin
			decide_next = S_LIT_HDR;
		end else if (acc_n_q != '0) begin
			decide_next = S_DONE;
		end else begin
			decide_next = S_IDLE;
		end
	end

	// literal store access
	always_ff @(posedge clk) begin
		if (state_q == S_ADD) begin
			mem[lc_q[AW-1:0]] <= rb_q;
		end
		if (rd_issue) begin
			rdata_s1 <= mem[idx_q[AW-1:0]];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			lc_q      <= '0;
			rc_q      <= '0;
			rb_q      <= '0;
			x_q       <= '0;
			end_q     <= 1'b0;
			ext_q     <= 1'b0;
			idx_q     <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (raw.valid) begin
						x_q     <= raw.in_byte;
						end_q   <= raw.row_end;
						ext_q   <= 1'b0;
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (!c0) begin
						rc_q  <= rc_n;
						ext_q <= 1'b1;
						if (!ext_q) begin
							rb_q <= x_q;
						end
					end
					state_q <= decide_next;
				end
				S_ADD: begin
					lc_q <= lc_q + CW'(1);
					rc_q <= rc_q - CW'(1);
					if (lc_q == CW'(MAX_PACKET - 1)) begin
						state_q <= S_LIT_HDR;
					end else if (rc_q == CW'(1)) begin
						state_q <= S_DECIDE;
					end
				end
				S_LIT_HDR: begin
					if (do_push) begin
						idx_q     <= '0;
						rvalid_s1 <= 1'b0;
						state_q   <= S_LIT_DAT;
					end
				end
				S_LIT_DAT: begin
					if (rd_issue) begin
						idx_q     <= idx_q + CW'(1);
						rvalid_s1 <= 1'b1;
					end else if (do_push) begin
						rvalid_s1 <= 1'b0;
					end
					if (lit_last) begin
						lc_q    <= '0;
						state_q <= S_DECIDE;
					end
				end
				S_RUN_HDR: begin
					if (do_push) begin
						state_q <= S_RUN_BYT;
					end
				end
				S_RUN_BYT: begin
					if (do_push) begin
						rc_q    <= '0;
						state_q <= S_DECIDE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// packer: a full word goes out only when the next byte arrives, so the
	// step's last word always leaves from the done state with the row flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			acc_n_q     <= '0;
			out_valid_q <= 1'b0;
			out_bytes_q <= '0;
			out_count_q <= '0;
			out_done_q  <= 1'b0;
		end else begin
			if (do_push) begin
				if (acc_full) begin
					out_valid_q <= 1'b1;
					out_bytes_q <= acc_q;
					out_count_q <= acc_n_q;
					out_done_q  <= 1'b0;
					acc_q       <= beat_t'(push_byte);
					acc_n_q     <= count_t'(1);
				end else begin
					acc_q[{acc_n_q[2:0], 3'b000} +: BYTE_W] <= push_byte;
					acc_n_q <= acc_n_q + count_t'(1);
					if (enc.ready) begin
						out_valid_q <= 1'b0;
					end
				end
			end else if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
				out_bytes_q <= acc_q;
				out_count_q <= acc_n_q;
				out_done_q  <= end_q;
				acc_q       <= '0;
				acc_n_q     <= '0;
			end else if (enc.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef ASSERT_OFF
	// between items no stretch or literal buffer is left full
	a_idle_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (lc_q < CW'(MAX_PACKET)) && (rc_q < CW'(MAX_PACKET)))
		else $error("count reached packet limit between items");

	// the packer never holds more than one word
	a_acc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		acc_n_q <= count_t'(BEAT_BYTES))
		else $error("packer overfilled");

	// flush reads stay inside the filled part of the store
	a_flush_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LIT_DAT) |-> (idx_q <= lc_q))
		else $error("flush read past literal count");

	// an accepted byte is decided on the next cycle
	a_accept_decide: assert property (@(posedge clk) disable iff (!arst_n)
		(raw.valid && raw.ready) |=> (state_q == S_DECIDE))
		else $error("accepted byte not decided");
`endif

endmodule

`default_nettype wire
